/* design/rgb565_nearest_downscale_to_int8_defines.svh */
// Assertion macros shared by the downscaler RTL.
`ifndef RGB565_NEAREST_DOWNSCALE_TO_INT8_DEFINES_SVH
`define RGB565_NEAREST_DOWNSCALE_TO_INT8_DEFINES_SVH

// Condition and consequence in the same cycle.
`define RND_ASSERT_SAME(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define RND_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* design/rnd_pkg.sv */
// Shared types and constants of the RGB565 nearest-neighbor downscaler.
`timescale 1ns / 1ps
package rnd_pkg;

    localparam int DEFAULT_MAX_DIM = 2048;
    localparam int REG_W           = 12;
    localparam int IDX_W           = 22;
    localparam int PIX_W           = 16;
    localparam int CFG_IDX_W       = 2;

    typedef logic [REG_W-1:0]     reg_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic signed [7:0]    chan_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_TARGET_WIDTH  = 2'd2,
        CFG_TARGET_HEIGHT = 2'd3
    } cfg_reg_t;

    localparam reg_t RST_SOURCE_WIDTH  = 12'd320;
    localparam reg_t RST_SOURCE_HEIGHT = 12'd240;
    localparam reg_t RST_TARGET_WIDTH  = 12'd96;
    localparam reg_t RST_TARGET_HEIGHT = 12'd96;

endpackage

/* design/rnd_ifs.sv */
// Valid/ready stream interfaces for the pixel input and the result output.
`timescale 1ns / 1ps
interface rnd_pix_if import rnd_pkg::*; ();
    logic valid;
    logic ready;
    pix_t pixel_word;
    logic frame_start;

    modport source (output valid, output pixel_word, output frame_start, input ready);
    modport sink   (input valid, input pixel_word, input frame_start, output ready);
endinterface

interface rnd_res_if import rnd_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t red_value;
    chan_t green_value;
    chan_t blue_value;
    idx_t  pixel_index;
    logic  frame_last;

    modport source (output valid, output red_value, output green_value, output blue_value,
                    output pixel_index, output frame_last, input ready);
    modport sink   (input valid, input red_value, input green_value, input blue_value,
                    input pixel_index, input frame_last, output ready);
endinterface

/* design/rnd_cfg.sv */
// Size registers with clamping to the supported range and to downscale only.
`timescale 1ns / 1ps
module rnd_cfg import rnd_pkg::*; #(
    parameter int MAX_DIM = DEFAULT_MAX_DIM,
    localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  cfg_idx_t         cfg_index,
    input  reg_t             cfg_data,
    output logic [DIM_W-1:0] sw,
    output logic [DIM_W-1:0] sh,
    output logic [DIM_W-1:0] tw,
    output logic [DIM_W-1:0] th
);

    reg_t src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;

    // Zero acts as one, then the value is limited to the given ceiling.
    function automatic logic [DIM_W-1:0] clamp(input reg_t v, input logic [DIM_W-1:0] top);
        int t;
        t = int'(v);
        if (t == 0) t = 1;
        if (t > MAX_DIM) t = MAX_DIM;
        if (t > int'(top)) t = int'(top);
        return DIM_W'(t);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= RST_SOURCE_WIDTH;
            src_h_reg <= RST_SOURCE_HEIGHT;
            dst_w_reg <= RST_TARGET_WIDTH;
            dst_h_reg <= RST_TARGET_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                CFG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                CFG_TARGET_WIDTH:  dst_w_reg <= cfg_data;
                CFG_TARGET_HEIGHT: dst_h_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign sw = clamp(src_w_reg, DIM_W'(MAX_DIM));
    assign sh = clamp(src_h_reg, DIM_W'(MAX_DIM));
    assign tw = clamp(dst_w_reg, sw);
    assign th = clamp(dst_h_reg, sh);

endmodule

/* design/rgb565_nearest_downscale_to_int8.sv */
// Top level of the RGB565 nearest-neighbor downscaler with signed 8-bit channel output.
// The block takes one RGB565 pixel per clock in raster order and shows each kept pixel in the
// next cycle from an output register, as signed R, G and B (channel shifted up to 8 bits,
// minus 128) with its output index and an end-of-frame flag. It accepts a new pixel in every
// cycle while the output register is empty or being drained, so the sustained rate is one
// pixel per clock; that figure is set by the combinational compare-and-add column and row
// selection on running accumulators. A pixel with frame_start set restarts all position
// counters. Target sizes above the source size are clamped to it, and zero acts as one.
`timescale 1ns / 1ps
`include "rgb565_nearest_downscale_to_int8_defines.svh"
module rgb565_nearest_downscale_to_int8 import rnd_pkg::*; #(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  cfg_idx_t  cfg_index,
    input  reg_t      cfg_data,
    rnd_pix_if.sink   pixel,
    rnd_res_if.source result
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int ACC_W = 2 * DIM_W;

    typedef logic [DIM_W-1:0] dim_t;
    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [ACC_W:0]   sum_t;

    dim_t sw, sh, tw, th;

    rnd_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sw        (sw),
        .sh        (sh),
        .tw        (tw),
        .th        (th)
    );

    dim_t src_col_reg, src_row_reg, dst_col_reg, dst_row_reg;
    dim_t src_col_next, src_row_next, dst_col_next, dst_row_next;
    acc_t col_tacc_reg, col_sacc_reg, row_tacc_reg, row_sacc_reg;
    acc_t col_tacc_next, col_sacc_next, row_tacc_next, row_sacc_next;
    idx_t out_count_reg, out_count_next;

    dim_t src_col_cur, src_row_cur, dst_col_cur, dst_row_cur;
    acc_t col_tacc_cur, col_sacc_cur, row_tacc_cur, row_sacc_cur;
    idx_t out_count_cur;

    logic accept, keep, row_sel, col_sel, row_end, last_pix;

    logic  res_valid_reg, res_valid_next;
    chan_t red_reg, green_reg, blue_reg;
    idx_t  index_reg;
    logic  last_reg;

    assign pixel.ready = !res_valid_reg || result.ready;
    assign accept      = pixel.valid && pixel.ready;

    // Frame start clears every counter before the pixel is looked at.
    always_comb
    begin
        if (pixel.frame_start)
        begin
            src_col_cur   = '0;
            src_row_cur   = '0;
            dst_col_cur   = '0;
            dst_row_cur   = '0;
            col_tacc_cur  = '0;
            col_sacc_cur  = '0;
            row_tacc_cur  = '0;
            row_sacc_cur  = '0;
            out_count_cur = '0;
        end
        else
        begin
            src_col_cur   = src_col_reg;
            src_row_cur   = src_row_reg;
            dst_col_cur   = dst_col_reg;
            dst_row_cur   = dst_row_reg;
            col_tacc_cur  = col_tacc_reg;
            col_sacc_cur  = col_sacc_reg;
            row_tacc_cur  = row_tacc_reg;
            row_sacc_cur  = row_sacc_reg;
            out_count_cur = out_count_reg;
        end
    end

    // A source position is kept while the target accumulator has not passed the next
    // source step, which matches floor(x * W / w) without a divider.
    assign row_sel  = (dst_row_cur < th)
                   && (sum_t'(row_tacc_cur) < (sum_t'(row_sacc_cur) + sum_t'(th)));
    assign col_sel  = (dst_col_cur < tw)
                   && (sum_t'(col_tacc_cur) < (sum_t'(col_sacc_cur) + sum_t'(tw)));
    assign keep     = row_sel && col_sel;
    assign row_end  = (src_col_cur >= (sw - 1'b1));
    assign last_pix = (dst_row_cur == (th - 1'b1)) && (dst_col_cur == (tw - 1'b1));

    always_comb
    begin
        src_col_next   = src_col_cur + 1'b1;
        src_row_next   = src_row_cur;
        dst_col_next   = col_sel ? dst_col_cur + 1'b1 : dst_col_cur;
        dst_row_next   = dst_row_cur;
        col_tacc_next  = col_sel ? col_tacc_cur + acc_t'(sw) : col_tacc_cur;
        col_sacc_next  = col_sacc_cur + acc_t'(tw);
        row_tacc_next  = row_tacc_cur;
        row_sacc_next  = row_sacc_cur;
        out_count_next = keep ? out_count_cur + 1'b1 : out_count_cur;

        if (row_end)
        begin
            src_col_next  = '0;
            dst_col_next  = '0;
            col_tacc_next = '0;
            col_sacc_next = '0;
            if (src_row_cur >= (sh - 1'b1))
            begin
                src_row_next   = '0;
                dst_row_next   = '0;
                row_tacc_next  = '0;
                row_sacc_next  = '0;
                out_count_next = '0;
            end
            else
            begin
                src_row_next  = src_row_cur + 1'b1;
                row_sacc_next = row_sacc_cur + acc_t'(th);
                if (row_sel)
                begin
                    dst_row_next  = dst_row_cur + 1'b1;
                    row_tacc_next = row_tacc_cur + acc_t'(sh);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            dst_col_reg   <= '0;
            dst_row_reg   <= '0;
            col_tacc_reg  <= '0;
            col_sacc_reg  <= '0;
            row_tacc_reg  <= '0;
            row_sacc_reg  <= '0;
            out_count_reg <= '0;
        end
        else if (accept)
        begin
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            dst_col_reg   <= dst_col_next;
            dst_row_reg   <= dst_row_next;
            col_tacc_reg  <= col_tacc_next;
            col_sacc_reg  <= col_sacc_next;
            row_tacc_reg  <= row_tacc_next;
            row_sacc_reg  <= row_sacc_next;
            out_count_reg <= out_count_next;
        end
    end

    // The output register holds a result until its transfer; a new one may load in the
    // same cycle.
    always_comb
    begin
        if (accept)
            res_valid_next = keep;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // Subtracting 128 from an 8-bit value only inverts its top bit.
    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            red_reg   <= {~pixel.pixel_word[15], pixel.pixel_word[14:11], 3'b000};
            green_reg <= {~pixel.pixel_word[10], pixel.pixel_word[9:5], 2'b00};
            blue_reg  <= {~pixel.pixel_word[4], pixel.pixel_word[3:0], 3'b000};
            index_reg <= out_count_cur;
            last_reg  <= last_pix;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.red_value   = red_reg;
    assign result.green_value = green_reg;
    assign result.blue_value  = blue_reg;
    assign result.pixel_index = index_reg;
    assign result.frame_last  = last_reg;

    `RND_ASSERT_SAME(a_ready_when_empty, !res_valid_reg, pixel.ready, "input stalled with empty output register")
    `RND_ASSERT_NEXT(a_frame_start_kept, accept && pixel.frame_start, result.valid && (result.pixel_index == '0), "first pixel of a frame not emitted as index zero")
    `RND_ASSERT_NEXT(a_index_follows_count, accept && keep, result.valid && (result.pixel_index == $past(out_count_cur)), "kept pixel index does not match output count")

endmodule

/* test/tb_rgb565_nearest_downscale_to_int8.sv */
// Self-checking testbench for the RGB565 nearest-neighbor downscaler.
`timescale 1ns / 1ps
module tb_rgb565_nearest_downscale_to_int8 import rnd_pkg::*; ();

    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_PCT    = 31;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        pix_t word;
        logic start;
    } cam_pixel_t;

    typedef struct {
        chan_t red;
        chan_t green;
        chan_t blue;
        idx_t  index;
        logic  last;
    } scaled_pixel_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_write;
    cfg_idx_t cfg_index;
    reg_t     cfg_data;

    rnd_pix_if pixel();
    rnd_res_if result();

    rgb565_nearest_downscale_to_int8 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .result    (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cam_pixel_t    camera_q[$];
    scaled_pixel_t kept_pixels_q[$];
    cam_pixel_t    next_pixel;
    scaled_pixel_t got_pixel;
    scaled_pixel_t want_pixel;

    bit no_idle = 1'b0;
    int mismatches = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    // Raw register contents and the position state of the downscaler.
    int unsigned reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
    int unsigned col_src, row_src, col_dst, row_dst;
    int unsigned col_dst_sum, col_src_sum, row_dst_sum, row_src_sum;
    int unsigned out_idx;

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_CAP)
            $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int unsigned size_eff(int unsigned v, int unsigned top);
        int unsigned s;
        s = (v == 0) ? 1 : v;
        if (s > DEFAULT_MAX_DIM)
            s = DEFAULT_MAX_DIM;
        if (s > top)
            s = top;
        return s;
    endfunction

    function automatic void clear_position();
        col_src = 0;
        row_src = 0;
        col_dst = 0;
        row_dst = 0;
        col_dst_sum = 0;
        col_src_sum = 0;
        row_dst_sum = 0;
        row_src_sum = 0;
        out_idx = 0;
    endfunction

    // Advances the position state by one camera pixel and queues the kept result.
    function automatic void downscale_pixel(pix_t word, logic start);
        int unsigned   sw, sh, tw, th;
        logic          keep_row, keep_col;
        scaled_pixel_t res;
        sw = size_eff(reg_src_w, DEFAULT_MAX_DIM);
        sh = size_eff(reg_src_h, DEFAULT_MAX_DIM);
        tw = size_eff(reg_dst_w, sw);
        th = size_eff(reg_dst_h, sh);
        if (start)
            clear_position();
        keep_row = (row_dst < th) && (row_dst_sum < row_src_sum + th);
        keep_col = (col_dst < tw) && (col_dst_sum < col_src_sum + tw);
        if (keep_row && keep_col)
        begin
            res.red   = chan_t'({word[15:11], 3'b000} - 8'd128);
            res.green = chan_t'({word[10:5], 2'b00} - 8'd128);
            res.blue  = chan_t'({word[4:0], 3'b000} - 8'd128);
            res.index = idx_t'(out_idx);
            res.last  = (row_dst == th - 1) && (col_dst == tw - 1);
            kept_pixels_q.push_back(res);
            out_idx = (out_idx + 1) % (1 << IDX_W);
        end
        if (keep_col)
        begin
            col_dst++;
            col_dst_sum += sw;
        end
        if (col_src >= sw - 1)
        begin
            col_src = 0;
            col_dst = 0;
            col_dst_sum = 0;
            col_src_sum = 0;
            if (keep_row)
            begin
                row_dst++;
                row_dst_sum += sh;
            end
            if (row_src >= sh - 1)
                clear_position();
            else
            begin
                row_src++;
                row_src_sum += th;
            end
        end
        else
        begin
            col_src++;
            col_src_sum += tw;
        end
    endfunction

    function automatic void push_pixel(pix_t word, logic start);
        cam_pixel_t item;
        item.word  = word;
        item.start = start;
        camera_q.push_back(item);
    endfunction

    // Mostly whole frames with a start mark on their first pixel, some left to wrap,
    // and a few stray start marks.
    task automatic queue_frames(int count, bit fresh);
        int unsigned frame_len;
        int unsigned pos;
        logic        start;
        frame_len = size_eff(reg_src_w, DEFAULT_MAX_DIM) * size_eff(reg_src_h, DEFAULT_MAX_DIM);
        pos = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                start = fresh;
            else
                start = (pos == 0 && $urandom_range(99) < 85) || ($urandom_range(99) < 3);
            if (start)
                pos = 0;
            push_pixel(pix_t'($urandom), start);
            pos = (pos + 1) % frame_len;
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= reg_t'(value);
        case (idx)
            CFG_SOURCE_WIDTH:  reg_src_w = value;
            CFG_SOURCE_HEIGHT: reg_src_h = value;
            CFG_TARGET_WIDTH:  reg_dst_w = value;
            CFG_TARGET_HEIGHT: reg_dst_h = value;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th);
        write_reg(CFG_SOURCE_WIDTH, sw);
        write_reg(CFG_SOURCE_HEIGHT, sh);
        write_reg(CFG_TARGET_WIDTH, tw);
        write_reg(CFG_TARGET_HEIGHT, th);
        settings_used++;
    endtask

    // Waits for every queued pixel to transfer and every kept pixel to come out.
    // The check runs at the falling edge, once the driver and monitor have settled.
    task automatic wait_idle();
        @(negedge clk);
        while (camera_q.size() != 0 || pixel.valid || kept_pixels_q.size() != 0
               || result.valid)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel.valid       <= 1'b0;
            pixel.pixel_word  <= '0;
            pixel.frame_start <= 1'b0;
        end
        else
        begin
            if (pixel.valid && pixel.ready)
            begin
                downscale_pixel(pixel.pixel_word, pixel.frame_start);
                pixels_sent++;
            end
            if (!pixel.valid || pixel.ready)
            begin
                if (camera_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_pixel = camera_q.pop_front();
                    pixel.valid       <= 1'b1;
                    pixel.pixel_word  <= next_pixel.word;
                    pixel.frame_start <= next_pixel.start;
                end
                else
                    pixel.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                got_pixel.red   = result.red_value;
                got_pixel.green = result.green_value;
                got_pixel.blue  = result.blue_value;
                got_pixel.index = result.pixel_index;
                got_pixel.last  = result.frame_last;
                if (kept_pixels_q.size() == 0)
                    report_mismatch($sformatf("unexpected result at index %0d", got_pixel.index));
                else
                begin
                    want_pixel = kept_pixels_q.pop_front();
                    if (got_pixel.red !== want_pixel.red)
                        report_mismatch($sformatf("index %0d red %0d, want %0d",
                            want_pixel.index, got_pixel.red, want_pixel.red));
                    if (got_pixel.green !== want_pixel.green)
                        report_mismatch($sformatf("index %0d green %0d, want %0d",
                            want_pixel.index, got_pixel.green, want_pixel.green));
                    if (got_pixel.blue !== want_pixel.blue)
                        report_mismatch($sformatf("index %0d blue %0d, want %0d",
                            want_pixel.index, got_pixel.blue, want_pixel.blue));
                    if (got_pixel.index !== want_pixel.index)
                        report_mismatch($sformatf("pixel_index %0d, want %0d",
                            got_pixel.index, want_pixel.index));
                    if (got_pixel.last !== want_pixel.last)
                        report_mismatch($sformatf("index %0d frame_last %b, want %b",
                            want_pixel.index, got_pixel.last, want_pixel.last));
                end
                pixels_checked++;
            end
            result.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Ends the run if neither side nor the register port moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (pixel.valid && pixel.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned sw, sh, tw, th;
        int          pick;
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = CFG_SOURCE_WIDTH;
        cfg_data          = '0;
        pixel.valid       = 1'b0;
        pixel.pixel_word  = '0;
        pixel.frame_start = 1'b0;
        result.ready      = 1'b0;
        reg_src_w = RST_SOURCE_WIDTH;
        reg_src_h = RST_SOURCE_HEIGHT;
        reg_dst_w = RST_TARGET_WIDTH;
        reg_dst_h = RST_TARGET_HEIGHT;
        clear_position();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Sizes left at their reset values: only a few columns are kept.
        push_pixel(16'hFFFF, 1'b1);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'hF800, 1'b0);
        push_pixel(16'h07E0, 1'b0);
        push_pixel(16'h001F, 1'b0);
        push_pixel(16'h8410, 1'b0);
        wait_idle();

        // Equal source and target sizes keep every pixel, so each channel extreme
        // comes out, followed by a wrap without a start mark and a restart mid-frame.
        set_sizes(4, 2, 4, 2);
        push_pixel(16'hFFFF, 1'b1);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'hF800, 1'b0);
        push_pixel(16'h07E0, 1'b0);
        push_pixel(16'h001F, 1'b0);
        push_pixel(16'h8410, 1'b0);
        push_pixel(16'h7BEF, 1'b0);
        push_pixel(16'h5555, 1'b0);
        push_pixel(16'hAAAA, 1'b0);
        push_pixel(16'h1234, 1'b0);
        push_pixel(16'hFEDC, 1'b1);
        push_pixel(16'h0F0F, 1'b0);
        wait_idle();

        for (int k = 0; k < 13; k++)
        begin
            case (k)
                0: begin sw = 4095; sh = 2;    tw = 4095; th = 0;    end
                1: begin sw = 2048; sh = 4095; tw = 1;    th = 2048; end
                2: begin sw = 0;    sh = 0;    tw = 0;    th = 0;    end
                3: begin sw = 7;    sh = 5;    tw = 9;    th = 9;    end
                4: begin sw = 1;    sh = 9;    tw = 1;    th = 4;    end
                default:
                begin
                    sw = $urandom_range(1, 16);
                    sh = $urandom_range(1, 10);
                    pick = $urandom_range(7);
                    tw = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(1, sw + 2);
                    pick = $urandom_range(7);
                    th = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(1, sh + 2);
                end
            endcase
            set_sizes(sw, sh, tw, th);
            no_idle = (k == 6);
            // Without a start mark the new sizes apply to a frame already under way.
            queue_frames($urandom_range(110, 150), $urandom_range(3) != 0);
            wait_idle();
        end
        no_idle = 1'b0;

        repeat (8) @(posedge clk);
        if (kept_pixels_q.size() != 0)
            report_mismatch($sformatf("%0d kept pixels never came out", kept_pixels_q.size()));
        $display("Sent %0d camera pixels under %0d size settings plus the reset sizes,",
            pixels_sent, settings_used);
        $display("and compared %0d downscaled pixels.", pixels_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/rnd_pkg.sv
design/rnd_ifs.sv
design/rnd_cfg.sv
design/rgb565_nearest_downscale_to_int8.sv
test/tb_rgb565_nearest_downscale_to_int8.sv
